/* rtl/tlb_translate_fifo_lru_defines.svh */
// ----------------------------------------------------------------------------
// tlb translate defines
// assertion macros shared by the tlb rtl
// ----------------------------------------------------------------------------
`ifndef TLB_TRANSLATE_FIFO_LRU_DEFINES_SVH
`define TLB_TRANSLATE_FIFO_LRU_DEFINES_SVH

// same-cycle implication
`define TLBFL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLBFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tlbfl_pkg.sv */
// ----------------------------------------------------------------------------
// tlb package
// transfer types, status codes, register indexes and sequencer states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlbfl_pkg;

   localparam logic [1:0] STATUS_HIT  = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FILL = 2'd2;

   localparam logic [1:0] CSR_PAGE_SIZE_LOG2 = 2'd0;
   localparam logic [1:0] CSR_TLB_ENTRIES    = 2'd1;
   localparam logic [1:0] CSR_REPLACE_LRU    = 2'd2;

   localparam logic MODE_TRANSLATE = 1'b0;

   typedef struct packed {
      logic        mode;
      logic [15:0] pid;
      logic [31:0] logical_address;
      logic [19:0] memory_frame;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] physical_address;
      logic [31:0] page_number;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pid;
      logic [31:0] page;
      logic [19:0] frame;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_TREAD,
      S_TCMP,
      S_LREAD,
      S_LCMP,
      S_WRITE
   } state_type;

endpackage

/* rtl/tlb_translate_fifo_lru.sv */
// ----------------------------------------------------------------------------
// tlb translate fifo lru
// fully associative tlb tagged by pid and page, fifo or lru replacement
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the result strobe rsp_valid, which lasts exactly one cycle and cannot be
// stalled. Entries live in one memory with a write port and a registered read
// port, read one slot at a time by a small sequencer with one tag comparator
// and one stamp comparator. A translate compares slots in order up to and
// including the first hit (at most the active count); an empty or disabled
// tlb misses without a read. A disabled tlb answers a fill without a write;
// a free slot or fifo replacement goes straight to the write, and lru
// replacement first scans the active slots for the oldest stamp. Free slots
// are tracked by a fill count, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tlb_translate_fifo_lru_defines.svh"

module tlb_translate_fifo_lru #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tlbfl_pkg::req_type req_data,
   output logic              rsp_valid,
   output tlbfl_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_wdata
);
   import tlbfl_pkg::*;

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int NW = (CW > 5) ? CW : 5;

   logic [4:0]    page_size_log2_ff;
   logic [4:0]    tlb_entries_ff;
   logic          replace_lru_ff;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [31:0]   page_ff, page_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] limit_ff, limit_in;
   logic [IW-1:0] best_ff, best_in;
   logic [31:0]   best_stamp_ff, best_stamp_in;
   logic [IW-1:0] victim_ff, victim_in;
   logic [NW-1:0] fill_count_ff, fill_count_in;
   logic [IW-1:0] oldest_ff, oldest_in;
   logic [31:0]   use_counter_ff, use_counter_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   entry_type     mem [MAX_ENTRIES];
   entry_type     rdata_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;

   logic [NW-1:0] active_n;
   logic [NW-1:0] search_n;
   logic [NW-1:0] idx_next;
   logic [NW-1:0] fifo_best;
   logic [31:0]   page_w;
   logic [31:0]   offset_w;
   logic [19:0]   phys_frame;
   logic [31:0]   phys_w;
   logic          tag_match;
   logic          accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign active_n = (NW'(tlb_entries_ff) > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES)
                                                               : NW'(tlb_entries_ff);
   assign search_n = (fill_count_ff < active_n) ? fill_count_ff : active_n;
   assign idx_next = idx_ff + NW'(1);
   assign fifo_best = (NW'(oldest_ff) < active_n) ? NW'(oldest_ff) : '0;

   // shifters for page split and address build
   assign page_w = req_ff.logical_address >> page_size_log2_ff;
   assign offset_w = req_ff.logical_address & ~(32'hFFFF_FFFF << page_size_log2_ff);
   assign phys_frame = (state_ff == S_TCMP) ? rdata_ff.frame : req_ff.memory_frame;
   assign phys_w = (32'(phys_frame) << page_size_log2_ff) | offset_w;
   assign tag_match = (rdata_ff.pid == req_ff.pid) && (rdata_ff.page == page_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_log2_ff <= 5'd12;
         tlb_entries_ff <= 5'd16;
         replace_lru_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PAGE_SIZE_LOG2: page_size_log2_ff <= csr_wdata;
            CSR_TLB_ENTRIES:    tlb_entries_ff <= csr_wdata;
            CSR_REPLACE_LRU:    replace_lru_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_count_ff <= '0;
         oldest_ff <= '0;
         use_counter_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_count_ff <= fill_count_in;
         oldest_ff <= oldest_in;
         use_counter_ff <= use_counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      page_ff <= page_in;
      idx_ff <= idx_in;
      limit_ff <= limit_in;
      best_ff <= best_in;
      best_stamp_ff <= best_stamp_in;
      victim_ff <= victim_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[idx_ff[IW-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      page_in = page_ff;
      idx_in = idx_ff;
      limit_in = limit_ff;
      best_in = best_ff;
      best_stamp_in = best_stamp_ff;
      victim_in = victim_ff;
      fill_count_in = fill_count_ff;
      oldest_in = oldest_ff;
      use_counter_in = use_counter_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_waddr = victim_ff;
      mem_wdata = '{pid: req_ff.pid, page: page_ff, frame: req_ff.memory_frame,
                    stamp: use_counter_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            page_in = page_w;
            idx_in = '0;
            if (req_ff.mode == MODE_TRANSLATE) begin
               if (search_n == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '{status: STATUS_MISS, physical_address: '0,
                                  page_number: page_w};
                  state_in = S_IDLE;
               end else begin
                  limit_in = search_n;
                  state_in = S_TREAD;
               end
            end else if (active_n == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{status: STATUS_FILL, physical_address: phys_w,
                               page_number: page_w};
               state_in = S_IDLE;
            end else if (fill_count_ff < active_n) begin
               victim_in = fill_count_ff[IW-1:0];
               fill_count_in = fill_count_ff + NW'(1);
               state_in = S_WRITE;
            end else if (!replace_lru_ff) begin
               victim_in = fifo_best[IW-1:0];
               oldest_in = ((fifo_best + NW'(1)) < active_n) ? IW'(fifo_best + NW'(1)) : '0;
               state_in = S_WRITE;
            end else begin
               limit_in = active_n;
               state_in = S_LREAD;
            end
         end
         S_TREAD: begin
            state_in = S_TCMP;
         end
         S_TCMP: begin
            if (tag_match) begin
               mem_we = 1'b1;
               mem_waddr = idx_ff[IW-1:0];
               mem_wdata = '{pid: rdata_ff.pid, page: rdata_ff.page,
                             frame: rdata_ff.frame, stamp: use_counter_ff};
               use_counter_in = use_counter_ff + 32'd1;
               rsp_valid_in = 1'b1;
               rsp_data_in = '{status: STATUS_HIT, physical_address: phys_w,
                               page_number: page_ff};
               state_in = S_IDLE;
            end else if (idx_next >= limit_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{status: STATUS_MISS, physical_address: '0,
                               page_number: page_ff};
               state_in = S_IDLE;
            end else begin
               idx_in = idx_next;
               state_in = S_TREAD;
            end
         end
         S_LREAD: begin
            state_in = S_LCMP;
         end
         S_LCMP: begin
            if ((idx_ff == '0) || (rdata_ff.stamp < best_stamp_ff)) begin
               best_in = idx_ff[IW-1:0];
               best_stamp_in = rdata_ff.stamp;
            end
            if (idx_next >= limit_ff) begin
               victim_in = best_in;
               state_in = S_WRITE;
            end else begin
               idx_in = idx_next;
               state_in = S_LREAD;
            end
         end
         S_WRITE: begin
            mem_we = 1'b1;
            use_counter_in = use_counter_ff + 32'd1;
            rsp_valid_in = 1'b1;
            rsp_data_in = '{status: STATUS_FILL, physical_address: phys_w,
                            page_number: page_ff};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `TLBFL_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE,
      "result strobe while sequencer busy")
   `TLBFL_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy,
      "not busy after transfer")
   `TLBFL_ASSERT_NOW(a_fill_count_bound, clock, reset, 1'b1,
      fill_count_ff <= NW'(MAX_ENTRIES), "fill count beyond entry count")
   `TLBFL_ASSERT_NOW(a_hit_stamps, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == STATUS_HIT),
      use_counter_ff == $past(use_counter_ff) + 32'd1, "hit without stamp update")

endmodule
